### sv/bpe_pkg.sv
`default_nettype none
package bpe_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_POINTS     = 16;
    localparam int NUM_COORDS     = 3;

    // operation codes of an input request
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // basis_mode register codes
    localparam logic MODE_BEZIER  = 1'b0;
    localparam logic MODE_BSPLINE = 1'b1;

endpackage
`default_nettype wire

### sv/bpe_if.sv
`default_nettype none
interface bpe_in_if #(
    parameter int COORD_BITS = bpe_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bpe_pkg::FRAC_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [3:0]                   point_index;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [FRAC_BITS+2:0]  u_param;
    logic signed [FRAC_BITS+2:0]  v_param;

    modport source (
        output valid, operation, point_index, point_x, point_y, point_z,
               u_param, v_param,
        input  ready
    );
    modport sink (
        input  valid, operation, point_index, point_x, point_y, point_z,
               u_param, v_param,
        output ready
    );
endinterface

interface bpe_out_if #(
    parameter int COORD_BITS = bpe_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] surface_x;
    logic signed [COORD_BITS-1:0] surface_y;
    logic signed [COORD_BITS-1:0] surface_z;

    modport source (output valid, surface_x, surface_y, surface_z, input ready);
    modport sink (input valid, surface_x, surface_y, surface_z, output ready);
endinterface
`default_nettype wire

### sv/bicubic_patch_point_evaluator.sv
// Bicubic patch point evaluator.
// i_in carries requests: a load (operation 0) writes control point
// point_index (x, y, z) into a 16-row store; an evaluate (operation 1) clamps
// u_param and v_param to 0..1 and returns the weighted patch point on o_out.
// i_cfg_we/i_cfg_wdata write basis_mode (0 Bezier, 1 uniform B-spline).
// A load gives no result. An evaluate runs on a single
// shared multiplier, each multiply split into an issue and a write-back step:
// basis weights for u then v (6 multiplies each for Bezier, 8 for B-spline),
// then 16 pair weights with 3 coordinate multiply-accumulates each. The
// result goes to the output register after the final step; i_in.ready is
// low from the accepted request until then and returns high together with
// the result, so a new request is taken only once the last one is done.
// The result sits in an output register: while the receiver stalls, loads
// and a new evaluate are still accepted; the next evaluate holds in its
// final cycle until the waiting result is taken.
// Reset marks all control points as zero and selects the Bezier basis.
`default_nettype none
module bicubic_patch_point_evaluator #(
    parameter int COORD_BITS = bpe_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bpe_pkg::FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    bpe_in_if.sink     i_in,
    bpe_out_if.source  o_out
);
    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int W_W   = F + 2;
    localparam int NW    = F + 6;
    localparam int MA_W  = (C > F + 5) ? C : F + 5;
    localparam int B_W   = F + 8;
    localparam int P_W   = MA_W + B_W + 1;
    localparam int ACC_W = P_W + 4;
    localparam int DIV_K = F + 10;
    localparam logic [B_W-1:0] DIV6_M =
        B_W'(((64'd1 << DIV_K) / 64'd6) + 64'd1);
    localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASIS = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;

    localparam logic [2:0] ST_TT = 3'd0;
    localparam logic [2:0] ST_SS = 3'd1;
    localparam logic [2:0] ST_C  = 3'd2;
    localparam logic [2:0] ST_T3 = 3'd3;
    localparam logic [2:0] ST_W4 = 3'd4;
    localparam logic [2:0] ST_W5 = 3'd5;
    localparam logic [2:0] ST_W6 = 3'd6;
    localparam logic [2:0] ST_W7 = 3'd7;

    logic [2:0]  r_state;
    logic        r_ph;
    logic        r_par;
    logic [2:0]  r_step;
    logic [3:0]  r_ij;
    logic [1:0]  r_k;
    logic        r_mode;
    logic [15:0] r_valid;
    logic        r_out_valid;

    logic [F:0]     r_tu, r_tv;
    logic [W_W-1:0] r_t2, r_s2, r_c, r_t3, r_w;
    logic [W_W-1:0] r_wu [4];
    logic [W_W-1:0] r_wv [4];
    logic signed [P_W-1:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [C-1:0]     r_ox, r_oy, r_oz;

    logic [3*C-1:0] r_mem [bpe_pkg::NUM_POINTS];
    logic [3*C-1:0] r_row;
    logic           r_row_vld;

    logic in_acc, out_acc;
    logic [F:0] t_cur, s_cur, u_clamp, v_clamp;
    logic [NW-1:0] n1a, n1b, n2a, n2b, n1, n2;
    logic signed [MA_W-1:0] mul_a;
    logic [B_W-1:0] mul_b;
    logic signed [P_W-1:0] mul_p;
    logic [W_W-1:0] rnd_v, div_v;
    logic [2:0] last_step;
    logic [3:0] n_wmask;
    logic [W_W-1:0] n_wd [4];
    logic [1:0] k_sel;
    logic signed [C-1:0] coord;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] fin [3];
    logic signed [C-1:0] sat [3];

    function automatic logic [F:0] clamp_p(input logic signed [F+2:0] p);
        logic [F:0] r;
        if (p[F+2]) begin
            r = '0;
        end else if (p[F+1:0] > (F+2)'(ONE_Q)) begin
            r = ONE_Q;
        end else begin
            r = p[F:0];
        end
        return r;
    endfunction

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = r_out_valid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign u_clamp = clamp_p(i_in.u_param);
    assign v_clamp = clamp_p(i_in.v_param);

    assign t_cur = r_par ? r_tv : r_tu;
    assign s_cur = ONE_Q - t_cur;
    assign last_step = (r_mode == bpe_pkg::MODE_BSPLINE) ? ST_W7 : ST_W5;

    // B-spline middle numerators, held at zero where negative
    assign n1a = (NW'(r_t3) << 1) + NW'(r_t3) + (NW'(ONE_Q) << 2);
    assign n1b = (NW'(r_t2) << 2) + (NW'(r_t2) << 1);
    assign n2a = (NW'(r_t2) << 1) + NW'(r_t2) + (NW'(t_cur) << 1) + NW'(t_cur)
               + NW'(ONE_Q);
    assign n2b = (NW'(r_t3) << 1) + NW'(r_t3);
    assign n1  = (n1a > n1b) ? n1a - n1b : '0;
    assign n2  = (n2a > n2b) ? n2a - n2b : '0;

    assign k_sel = r_k - 2'd1;
    assign coord = r_row_vld ? $signed(r_row[k_sel*C +: C]) : '0;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_BASIS) begin
            unique case (r_step)
                ST_TT: begin mul_a = MA_W'(t_cur); mul_b = B_W'(t_cur); end
                ST_SS: begin mul_a = MA_W'(s_cur); mul_b = B_W'(s_cur); end
                ST_C:  begin mul_a = MA_W'(r_s2);  mul_b = B_W'(s_cur); end
                ST_T3: begin mul_a = MA_W'(r_t2);  mul_b = B_W'(t_cur); end
                ST_W4: begin
                    if (r_mode == bpe_pkg::MODE_BSPLINE) begin
                        mul_a = MA_W'(r_c) + MA_W'(3);
                        mul_b = DIV6_M;
                    end else begin
                        mul_a = (MA_W'(t_cur) << 1) + MA_W'(t_cur);
                        mul_b = B_W'(r_s2);
                    end
                end
                ST_W5: begin
                    if (r_mode == bpe_pkg::MODE_BSPLINE) begin
                        mul_a = MA_W'(n1) + MA_W'(3);
                        mul_b = DIV6_M;
                    end else begin
                        mul_a = (MA_W'(r_t2) << 1) + MA_W'(r_t2);
                        mul_b = B_W'(s_cur);
                    end
                end
                ST_W6: begin mul_a = MA_W'(n2) + MA_W'(3);   mul_b = DIV6_M; end
                ST_W7: begin mul_a = MA_W'(r_t3) + MA_W'(3); mul_b = DIV6_M; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == S_ACC) begin
            if (r_k == 2'd0) begin
                mul_a = MA_W'(r_wu[r_ij[3:2]]);
                mul_b = B_W'(r_wv[r_ij[1:0]]);
            end else begin
                mul_a = MA_W'(coord);
                mul_b = B_W'(r_w);
            end
        end
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    assign rnd_v = W_W'((r_prod + P_W'(ONE_Q >> 1)) >>> F);
    assign div_v = W_W'(r_prod >>> DIV_K);
    assign prod_ext = ACC_W'(r_prod);

    // weight write-back for the current parameter
    always_comb begin
        n_wmask = '0;
        for (int e = 0; e < 4; e++) begin
            n_wd[e] = div_v;
        end
        if (r_state == S_BASIS && r_ph) begin
            unique case (r_step)
                ST_W4: begin
                    if (r_mode == bpe_pkg::MODE_BSPLINE) begin
                        n_wmask = 4'b0001;
                    end else begin
                        n_wmask = 4'b0010;
                        n_wd[1] = rnd_v;
                    end
                end
                ST_W5: begin
                    if (r_mode == bpe_pkg::MODE_BSPLINE) begin
                        n_wmask = 4'b0010;
                    end else begin
                        n_wmask = 4'b1101;
                        n_wd[0] = r_c;
                        n_wd[2] = rnd_v;
                        n_wd[3] = r_t3;
                    end
                end
                ST_W6: n_wmask = 4'b0100;
                ST_W7: n_wmask = 4'b1000;
                default: n_wmask = '0;
            endcase
        end
    end

    // round, floor-shift and saturate each sum
    always_comb begin
        for (int q = 0; q < 3; q++) begin
            fin[q] = (r_acc[q] + $signed(ACC_W'(ONE_Q >> 1))) >>> F;
            if (fin[q] > $signed({{(ACC_W-C+1){1'b0}}, {(C-1){1'b1}}})) begin
                sat[q] = {1'b0, {(C-1){1'b1}}};
            end else if (fin[q] < $signed({{(ACC_W-C+1){1'b1}}, {(C-1){1'b0}}})) begin
                sat[q] = {1'b1, {(C-1){1'b0}}};
            end else begin
                sat[q] = fin[q][C-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.operation == bpe_pkg::OP_LOAD) begin
            r_mem[i_in.point_index] <= {i_in.point_z, i_in.point_y, i_in.point_x};
        end
        r_row <= r_mem[r_ij];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ph        <= 1'b0;
            r_par       <= 1'b0;
            r_step      <= '0;
            r_ij        <= '0;
            r_k         <= '0;
            r_mode      <= bpe_pkg::MODE_BEZIER;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_row_vld   <= 1'b0;
        end else begin
            r_row_vld <= r_valid[r_ij];
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            // load a finished result, or drop the one just taken
            if (r_state == S_FIN && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.operation == bpe_pkg::OP_LOAD) begin
                            r_valid[i_in.point_index] <= 1'b1;
                        end else begin
                            r_state <= S_BASIS;
                            r_ph    <= 1'b0;
                            r_par   <= 1'b0;
                            r_step  <= '0;
                        end
                    end
                end
                S_BASIS: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        if (r_step == last_step) begin
                            r_step <= '0;
                            r_par  <= 1'b1;
                            if (r_par) begin
                                r_state <= S_ACC;
                                r_ij    <= '0;
                                r_k     <= '0;
                            end
                        end else begin
                            r_step <= r_step + 3'd1;
                        end
                    end
                end
                S_ACC: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        // r_k wraps to zero after the last coordinate
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            if (r_ij == 4'd15) begin
                                r_state <= S_FIN;
                            end else begin
                                r_ij <= r_ij + 4'd1;
                            end
                        end
                    end
                end
                S_FIN: begin
                    // hold until the previous result has left
                    if (!r_out_valid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.operation == bpe_pkg::OP_EVAL) begin
            r_tu <= u_clamp;
            r_tv <= v_clamp;
            for (int q = 0; q < 3; q++) begin
                r_acc[q] <= '0;
            end
        end
        if (!r_ph) begin
            r_prod <= mul_p;
        end
        if (r_state == S_BASIS && r_ph) begin
            unique case (r_step)
                ST_TT: r_t2 <= rnd_v;
                ST_SS: r_s2 <= rnd_v;
                ST_C:  r_c  <= rnd_v;
                ST_T3: r_t3 <= rnd_v;
                default: r_t2 <= r_t2;
            endcase
        end
        for (int e = 0; e < 4; e++) begin
            if (n_wmask[e]) begin
                if (r_par) begin
                    r_wv[e] <= n_wd[e];
                end else begin
                    r_wu[e] <= n_wd[e];
                end
            end
        end
        if (r_state == S_ACC && r_ph) begin
            if (r_k == 2'd0) begin
                r_w <= rnd_v;
            end else begin
                r_acc[k_sel] <= r_acc[k_sel] + prod_ext;
            end
        end
        if (r_state == S_FIN && (!r_out_valid || o_out.ready)) begin
            r_ox <= sat[0];
            r_oy <= sat[1];
            r_oz <= sat[2];
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.surface_x = r_ox;
    assign o_out.surface_y = r_oy;
    assign o_out.surface_z = r_oz;

    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.operation == bpe_pkg::OP_EVAL) |=> (r_state == S_BASIS))
        else $error("evaluate request did not start the basis sequence");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.operation == bpe_pkg::OP_LOAD) |=> (r_state == S_IDLE))
        else $error("load request left the idle state");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result appeared outside the final step");

    a_pair_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_k != 2'd0) |-> (r_w <= W_W'(ONE_Q)))
        else $error("pair weight above one");

    a_basis_to_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BASIS && !r_par) |=> (r_state == S_BASIS))
        else $error("accumulation began before the second parameter");

endmodule
`default_nettype wire

### tb/sv/tb_bicubic_patch_point_evaluator.sv
`default_nettype none
module tb_bicubic_patch_point_evaluator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = bpe_pkg::COORD_BITS_DEF;
    localparam int FB = bpe_pkg::FRAC_BITS_DEF;
    localparam logic [63:0] ONE = 64'd1 << FB;
    localparam logic [63:0] HALF = 64'd1 << (FB - 1);
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic                 op;
        logic [3:0]           idx;
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic signed [CB-1:0] pz;
        logic signed [FB+2:0] u;
        logic signed [FB+2:0] v;
    } t_request;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
    } t_point;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    bpe_in_if  #(.COORD_BITS(CB), .FRAC_BITS(FB)) req_if ();
    bpe_out_if #(.COORD_BITS(CB)) res_if ();

    bicubic_patch_point_evaluator #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (req_if.sink),
        .o_out      (res_if.source)
    );

    t_request pending_reqs[$];
    t_point   expected_points[$];
    t_point   cp_store[bpe_pkg::NUM_POINTS];
    logic     basis_sel;
    int       errors;
    bit       idle_enable;
    bit       drv_hold;
    bit       in_taken;
    int       stall_request;
    int       send_gap;
    int       recv_gap;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [63:0] rnd_q(logic [63:0] p);
        return (p + HALF) >> FB;
    endfunction

    function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    function automatic logic [63:0] clamp_t(logic signed [FB+2:0] raw);
        if (raw < 0) return 64'd0;
        if (raw > $signed(ONE[FB+2:0])) return ONE;
        return 64'(raw);
    endfunction

    function automatic void basis_weights(logic [63:0] t, logic bsp, output logic [63:0] w[4]);
        logic [63:0] s, t2, s2, c0, t3, n1, n2;
        s  = ONE - t;
        t2 = rnd_q(t * t);
        s2 = rnd_q(s * s);
        if (bsp == bpe_pkg::MODE_BEZIER) begin
            w[0] = rnd_q(s2 * s);
            w[1] = rnd_q(3 * t * s2);
            w[2] = rnd_q(3 * t2 * s);
            w[3] = rnd_q(t2 * t);
        end else begin
            c0 = rnd_q(s2 * s);
            t3 = rnd_q(t2 * t);
            n1 = sat_sub(3 * t3 + 4 * ONE, 6 * t2);
            n2 = sat_sub(3 * t2 + 3 * t + ONE, 3 * t3);
            w[0] = (c0 + 3) / 6;
            w[1] = (n1 + 3) / 6;
            w[2] = (n2 + 3) / 6;
            w[3] = (t3 + 3) / 6;
        end
    endfunction

    function automatic logic signed [CB-1:0] round_saturate(logic signed [127:0] acc);
        logic signed [127:0] q;
        q = (acc + 128'sd32768) >>> FB;
        if (q > 128'sd2147483647) return {1'b0, {(CB-1){1'b1}}};
        if (q < -128'sd2147483648) return {1'b1, {(CB-1){1'b0}}};
        return q[CB-1:0];
    endfunction

    function automatic t_point evaluate_patch(t_request r);
        logic [63:0] wu[4], wv[4], w;
        logic signed [127:0] ax, ay, az;
        t_point p;
        basis_weights(clamp_t(r.u), basis_sel, wu);
        basis_weights(clamp_t(r.v), basis_sel, wv);
        ax = 0; ay = 0; az = 0;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                w = rnd_q(wu[i] * wv[j]);
                ax += 128'(cp_store[i*4+j].x) * $signed({64'd0, w});
                ay += 128'(cp_store[i*4+j].y) * $signed({64'd0, w});
                az += 128'(cp_store[i*4+j].z) * $signed({64'd0, w});
            end
        end
        p.x = round_saturate(ax);
        p.y = round_saturate(ay);
        p.z = round_saturate(az);
        return p;
    endfunction

    // input monitor: update the patch model at acceptance so evaluates see loads in order
    always @(posedge i_clk) begin
        in_taken = i_rst_n && req_if.valid && req_if.ready;
        if (in_taken) begin
            if (req_if.operation == bpe_pkg::OP_EVAL) begin
                t_request r;
                r.op = req_if.operation;
                r.u = req_if.u_param;
                r.v = req_if.v_param;
                expected_points.insert(expected_points.size(), evaluate_patch(r));
            end else begin
                cp_store[req_if.point_index] = '{req_if.point_x, req_if.point_y, req_if.point_z};
            end
            void'(pending_reqs.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !in_taken) begin
            // hold the request until it is taken
            req_if.valid <= 1'b1;
        end else if (drv_hold || pending_reqs.size() == 0) begin
            req_if.valid <= 1'b0;
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_if.valid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 15);
            req_if.valid <= 1'b0;
        end else begin
            req_if.valid       <= 1'b1;
            req_if.operation   <= pending_reqs[0].op;
            req_if.point_index <= pending_reqs[0].idx;
            req_if.point_x     <= pending_reqs[0].px;
            req_if.point_y     <= pending_reqs[0].py;
            req_if.point_z     <= pending_reqs[0].pz;
            req_if.u_param     <= pending_reqs[0].u;
            req_if.v_param     <= pending_reqs[0].v;
        end
    end

    // receiver: long hold-off on request, otherwise random stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (stall_request > 0) begin
            stall_request <= stall_request - 1;
            res_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            res_if.ready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            recv_gap <= $urandom_range(1, 15);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            t_point want;
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                         res_if.surface_x, res_if.surface_y, res_if.surface_z);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (want.x !== res_if.surface_x) begin
                    $display("%0t: x expected %0d actual %0d", $time, want.x, res_if.surface_x);
                    errors++;
                end
                if (want.y !== res_if.surface_y) begin
                    $display("%0t: y expected %0d actual %0d", $time, want.y, res_if.surface_y);
                    errors++;
                end
                if (want.z !== res_if.surface_z) begin
                    $display("%0t: z expected %0d actual %0d", $time, want.z, res_if.surface_z);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(CB-1){1'b1}}};
            1: return {1'b1, {(CB-1){1'b0}}};
            2: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [FB+2:0] rand_param();
        case ($urandom_range(0, 7))
            0: return 19'sh20000;
            1: return -19'sh20000;
            2: return 19'sh10000;
            3: return '0;
            4: return 19'($urandom);
            default: return 19'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic push_load(int idx, logic signed [CB-1:0] x, y, z);
        t_request r;
        r = '{bpe_pkg::OP_LOAD, 4'(idx), x, y, z, 19'($urandom), 19'($urandom)};
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic push_eval(logic signed [FB+2:0] u, v);
        t_request r;
        r = '{bpe_pkg::OP_EVAL, 4'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
              u, v};
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic drain_all();
        while (pending_reqs.size() != 0 || expected_points.size() != 0 || req_if.valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(logic mode);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        basis_sel = mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 2) == 0) push_eval(rand_param(), rand_param());
            else push_load($urandom_range(0, 15), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial begin
        errors = 0;
        basis_sel = bpe_pkg::MODE_BEZIER;
        idle_enable = 1'b1;
        drv_hold = 1'b0;
        stall_request = 0;
        send_gap = 0;
        recv_gap = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        req_if.valid = 1'b0;
        req_if.operation = bpe_pkg::OP_LOAD;
        req_if.point_index = '0;
        req_if.point_x = '0;
        req_if.point_y = '0;
        req_if.point_z = '0;
        req_if.u_param = '0;
        req_if.v_param = '0;
        res_if.ready = 1'b0;
        foreach (cp_store[i]) cp_store[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero store, clamp edges, extreme coordinates for saturation
        push_eval(19'sh10000, 19'sh08000);
        for (int i = 0; i < 16; i++)
            push_load(i, {1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}}, 32'sh0001_0000 * i);
        push_eval(-19'sh20000, 19'sh20000);
        push_eval(19'sh0ffff, -19'sh1);
        push_eval(19'sh08000, 19'sh08000);
        push_eval(19'sh1ffff, 19'sh00001);
        drain_all();
        write_mode(bpe_pkg::MODE_BSPLINE);
        push_eval(19'sh08000, 19'sh08000);
        push_eval(19'sh0, 19'sh10000);
        push_eval(-19'sh1, 19'sh20000);

        // hold off the receiver while requests keep coming
        stall_request = 600;
        random_phase(40);
        drain_all();
        write_mode(bpe_pkg::MODE_BEZIER);
        random_phase(450);
        // sender waits for every outstanding result before continuing
        drv_hold = 1'b1;
        while (expected_points.size() != 0 || req_if.valid) @(posedge i_clk);
        drv_hold = 1'b0;
        drain_all();
        write_mode(bpe_pkg::MODE_BSPLINE);
        random_phase(450);
        drain_all();
        write_mode(bpe_pkg::MODE_BEZIER);
        idle_enable = 1'b0;
        random_phase(480);
        drain_all();

        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
